// ----- rtl/hsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

    // fixed field widths of the stream payload
    localparam int DATA_W   = 32;
    localparam int CODE_W   = 39;
    localparam int STATUS_W = 3;
    localparam int ERRPOS_W = 6;
    localparam int COUNT_W  = 32;

    // internal working word covers every position of the widest codeword
    localparam int WORD_W = 64;
    localparam int SYN_W  = 7;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    localparam logic [STATUS_W-1:0] STATUS_CLEAN      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_PARITY     = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_CORRECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE  = 3'd4;

    // classified request handed from front to back
    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] word;
        logic [SYN_W-1:0]  syn;
        logic              ovpar;
    } entry_t;

    // number of check bits for a given data width
    function automatic int check_count(input int data_bits);
        int r;
        r = 0;
        for (int i = 0; i < SYN_W; i++) begin
            if ((1 << r) < data_bits + r + 1) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    // place data bits at the non-power-of-two positions 1..n
    function automatic logic [WORD_W-1:0] spread_data(input logic [DATA_W-1:0] d,
                                                      input int n);
        logic [WORD_W-1:0] c;
        int k;
        c = '0;
        k = 0;
        for (int pos = 1; pos < WORD_W; pos++) begin
            if (pos <= n && (pos & (pos - 1)) != 0) begin
                if (k < DATA_W) begin
                    c[pos-1] = d[k];
                end
                k = k + 1;
            end
        end
        return c;
    endfunction

    // gather data bits back from the non-power-of-two positions
    function automatic logic [DATA_W-1:0] extract_data(input logic [WORD_W-1:0] w,
                                                       input int n);
        logic [DATA_W-1:0] d;
        int k;
        d = '0;
        k = 0;
        for (int pos = 1; pos < WORD_W; pos++) begin
            if (pos <= n && (pos & (pos - 1)) != 0) begin
                if (k < DATA_W) begin
                    d[k] = w[pos-1];
                end
                k = k + 1;
            end
        end
        return d;
    endfunction

    // one xor tree per check bit over positions 1..n
    function automatic logic [SYN_W-1:0] syndrome_of(input logic [WORD_W-1:0] w,
                                                     input int n);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int i = 0; i < SYN_W; i++) begin
            for (int pos = 1; pos < WORD_W; pos++) begin
                if (pos <= n && ((pos >> i) & 1) == 1) begin
                    s[i] = s[i] ^ w[pos-1];
                end
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hamming_secded_codec_top.sv -----
// extended hamming secded encoder / decoder, one request per s_ handshake
// a request accepted on s_ is written into a queue slot, then into the result register when the back pops it
// throughput: one request per cycle sustained while m_tready stays high; set by the single-pass xor trees per word
// a two-slot queue sits between the classify front and the result back, so either side stalls alone
// reset (aresetn low, synchronous): queue emptied, output invalid, all three tallies cleared
`timescale 1ns / 1ps
`default_nettype none

module hamming_secded_codec_top #(
    parameter int DATA_BITS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // data_word [31:0], received_code [70:32], zero pad [71]
    input  wire logic         s_tuser,   // opcode: 0 encode, 1 decode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [175:0]      m_tdata    // code_out [38:0], data_out [70:39], status [73:71],
                                         // error_position [79:74], encoded_count [111:80],
                                         // decoded_count [143:112], corrected_count [175:144]
);
    import hsc_pkg::*;

    localparam int CodeN = DATA_BITS + check_count(DATA_BITS);

    entry_t              front_entry;
    entry_t              head_entry;
    logic                head_valid;
    logic                head_pop;
    logic [CODE_W-1:0]   code_out;
    logic [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0] status;
    logic [ERRPOS_W-1:0] error_position;
    logic [COUNT_W-1:0]  encoded_count;
    logic [COUNT_W-1:0]  decoded_count;
    logic [COUNT_W-1:0]  corrected_count;

    // classify the incoming request
    hsc_front #(
        .CODE_N(CodeN)
    ) u_front (
        .op_in         (s_tuser),
        .data_word     (s_tdata[DATA_W-1:0]),
        .received_code (s_tdata[DATA_W+CODE_W-1:DATA_W]),
        .entry         (front_entry)
    );

    // decoupling queue
    hsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_entry (front_entry),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_entry (head_entry)
    );

    // finish encode or correct and register the result
    hsc_back #(
        .CODE_N(CodeN)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_pop        (head_pop),
        .head_entry      (head_entry),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .code_out        (code_out),
        .data_out        (data_out),
        .status          (status),
        .error_position  (error_position),
        .encoded_count   (encoded_count),
        .decoded_count   (decoded_count),
        .corrected_count (corrected_count)
    );

    // result packing, first field lowest
    assign m_tdata = {corrected_count, decoded_count, encoded_count,
                      error_position, status, data_out, code_out};

endmodule

`default_nettype wire

// ----- rtl/hsc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsc_front #(
    parameter int CODE_N = 38
) (
    input  wire logic                      op_in,
    input  wire logic [hsc_pkg::DATA_W-1:0] data_word,
    input  wire logic [hsc_pkg::CODE_W-1:0] received_code,
    output hsc_pkg::entry_t                entry
);
    import hsc_pkg::*;

    // positions 1..n plus the overall parity bit
    localparam logic [WORD_W-1:0] WordMask =
        (CODE_N + 1 >= WORD_W) ? {WORD_W{1'b1}}
                               : ((WORD_W'(1) << (CODE_N + 1)) - WORD_W'(1));

    op_t               op;
    logic [WORD_W-1:0] enc_word;
    logic [WORD_W-1:0] dec_word;
    logic [WORD_W-1:0] sel_word;

    // pick the word, then one shared syndrome tree and the overall parity
    always_comb begin
        op       = op_t'(op_in);
        enc_word = spread_data(data_word, CODE_N);
        dec_word = WORD_W'(received_code) & WordMask;
        sel_word = (op == OP_DECODE) ? dec_word : enc_word;

        entry.op    = op;
        entry.word  = sel_word;
        entry.syn   = syndrome_of(sel_word, CODE_N);
        entry.ovpar = ^sel_word;
    end

endmodule

`default_nettype wire

// ----- rtl/hsc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsc_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire hsc_pkg::entry_t  wr_entry,
    output logic                  rd_valid,
    input  wire logic             rd_pop,
    output hsc_pkg::entry_t       rd_entry
);
    import hsc_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    // two-slot queue status
    always_comb begin
        wr_ready    = (count_reg != 2'd2);
        rd_valid    = (count_reg != 2'd0);
        rd_entry    = slot_reg[rd_ptr_reg];
        do_wr       = wr_valid && wr_ready;
        do_rd       = rd_pop && rd_valid;
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hsc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsc_back #(
    parameter int CODE_N = 38
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        head_valid,
    output logic                             head_pop,
    input  wire hsc_pkg::entry_t             head_entry,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [hsc_pkg::CODE_W-1:0]       code_out,
    output logic [hsc_pkg::DATA_W-1:0]       data_out,
    output logic [hsc_pkg::STATUS_W-1:0]     status,
    output logic [hsc_pkg::ERRPOS_W-1:0]     error_position,
    output logic [hsc_pkg::COUNT_W-1:0]      encoded_count,
    output logic [hsc_pkg::COUNT_W-1:0]      decoded_count,
    output logic [hsc_pkg::COUNT_W-1:0]      corrected_count
);
    import hsc_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [CODE_W-1:0]   code_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ERRPOS_W-1:0] errpos_reg;
    logic [COUNT_W-1:0]  enc_tally_reg;
    logic [COUNT_W-1:0]  enc_tally_next;
    logic [COUNT_W-1:0]  dec_tally_reg;
    logic [COUNT_W-1:0]  dec_tally_next;
    logic [COUNT_W-1:0]  cor_tally_reg;
    logic [COUNT_W-1:0]  cor_tally_next;

    logic [WORD_W-1:0]   check_bits;
    logic [WORD_W-1:0]   enc_code;
    logic [WORD_W-1:0]   fixed_word;
    logic [ERRPOS_W-1:0] syn_m1;
    logic [CODE_W-1:0]   code_next;
    logic [DATA_W-1:0]   data_next;
    logic [STATUS_W-1:0] status_next;
    logic [ERRPOS_W-1:0] errpos_next;
    logic                corrected;

    // take the head when the output register is free or draining
    always_comb begin
        head_pop   = head_valid && (!valid_reg || out_ready);
        valid_next = head_pop ? 1'b1 : (valid_reg && !out_ready);
    end

    // encode: check bits at power-of-two positions, overall parity at bit n
    always_comb begin
        check_bits = '0;
        for (int i = 0; i < SYN_W; i++) begin
            check_bits[(1 << i) - 1] = head_entry.syn[i];
        end
        enc_code = head_entry.word | check_bits;
        enc_code = enc_code | (WORD_W'(^enc_code) << CODE_N);
    end

    // decode: classify the syndrome and fix a single error
    always_comb begin
        syn_m1      = ERRPOS_W'(head_entry.syn - SYN_W'(1));
        fixed_word  = head_entry.word;
        status_next = STATUS_CLEAN;
        errpos_next = '0;
        corrected   = 1'b0;
        code_next   = '0;
        data_next   = '0;
        if (head_entry.op == OP_ENCODE) begin
            code_next = enc_code[CODE_W-1:0];
        end else begin
            priority if (head_entry.syn == '0) begin
                status_next = head_entry.ovpar ? STATUS_PARITY : STATUS_CLEAN;
            end else if (!head_entry.ovpar) begin
                status_next = STATUS_DOUBLE;
            end else if (32'(head_entry.syn) <= 32'(CODE_N)) begin
                fixed_word  = head_entry.word ^ (WORD_W'(1) << syn_m1);
                status_next = STATUS_CORRECTED;
                errpos_next = syn_m1;
                corrected   = 1'b1;
            end else begin
                status_next = STATUS_OUT_RANGE;
            end
            data_next = extract_data(fixed_word, CODE_N);
        end
    end

    // running tallies, counted as the item enters the output register
    always_comb begin
        enc_tally_next = enc_tally_reg;
        dec_tally_next = dec_tally_reg;
        cor_tally_next = cor_tally_reg;
        if (head_pop) begin
            if (head_entry.op == OP_ENCODE) begin
                enc_tally_next = enc_tally_reg + COUNT_W'(1);
            end else begin
                dec_tally_next = dec_tally_reg + COUNT_W'(1);
            end
            if (corrected) begin
                cor_tally_next = cor_tally_reg + COUNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            enc_tally_reg <= '0;
            dec_tally_reg <= '0;
            cor_tally_reg <= '0;
        end else begin
            valid_reg     <= valid_next;
            enc_tally_reg <= enc_tally_next;
            dec_tally_reg <= dec_tally_next;
            cor_tally_reg <= cor_tally_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (head_pop) begin
            code_reg   <= code_next;
            data_reg   <= data_next;
            status_reg <= status_next;
            errpos_reg <= errpos_next;
        end
    end

    // tallies are sampled with the payload so each result carries its own counts
    logic [COUNT_W-1:0] enc_out_reg;
    logic [COUNT_W-1:0] dec_out_reg;
    logic [COUNT_W-1:0] cor_out_reg;

    always_ff @(posedge aclk) begin
        if (head_pop) begin
            enc_out_reg <= enc_tally_next;
            dec_out_reg <= dec_tally_next;
            cor_out_reg <= cor_tally_next;
        end
    end

    assign out_valid       = valid_reg;
    assign code_out        = code_reg;
    assign data_out        = data_reg;
    assign status          = status_reg;
    assign error_position  = errpos_reg;
    assign encoded_count   = enc_out_reg;
    assign decoded_count   = dec_out_reg;
    assign corrected_count = cor_out_reg;

endmodule

`default_nettype wire
